// File: hdl/sha256s_pkg.sv
// ----------------------------------------------------------------------------
// sha256s_pkg
// shared types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha256s_pkg;

    localparam int WORD_W = 32;
    localparam int HASH_N = 8;
    localparam int SCHED_N = 16;
    localparam int ROUNDS = 64;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam logic [WORD_W-1:0] IV [HASH_N] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    // message schedule window control
    typedef struct packed {
        logic push;
        logic shift;
    } t_sch_ctl;

    // round unit control
    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } t_rnd_ctl;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] sig0(input logic [WORD_W-1:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] sig1(input logic [WORD_W-1:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// File: hdl/sha256s_sched.sv
// ----------------------------------------------------------------------------
// sha256s_sched
// 16-word block buffer and message schedule window
// ----------------------------------------------------------------------------
module sha256s_sched (
    input  logic                 i_clk,
    input  sha256s_pkg::t_sch_ctl i_ctl,
    input  logic [7:0]           i_byte,
    output logic [31:0]          o_word
);

    logic [31:0] r_w [sha256s_pkg::SCHED_N];
    logic [31:0] n_w [sha256s_pkg::SCHED_N];

    always_comb begin
        n_w = r_w;
        if (i_ctl.push) begin
            // bytes enter at the low byte of the last word, big-endian within each word
            for (int i = 0; i < sha256s_pkg::SCHED_N - 1; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[sha256s_pkg::SCHED_N-1] = {r_w[sha256s_pkg::SCHED_N-1][23:0], i_byte};
        end else if (i_ctl.shift) begin
            for (int i = 0; i < sha256s_pkg::SCHED_N - 1; i++) begin
                n_w[i] = r_w[i+1];
            end
            // w[t+16] from the current window
            n_w[sha256s_pkg::SCHED_N-1] = sha256s_pkg::sig1(r_w[14]) + r_w[9]
                                        + sha256s_pkg::sig0(r_w[1]) + r_w[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_word = r_w[0];

endmodule

// File: hdl/sha256s_round.sv
// ----------------------------------------------------------------------------
// sha256s_round
// hash state, working variables and the shared compression round
// ----------------------------------------------------------------------------
module sha256s_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256s_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]          i_k,
    input  logic [31:0]          i_w,
    input  logic [2:0]           i_sel,
    output logic [31:0]          o_hash
);

    logic [31:0] r_hash [sha256s_pkg::HASH_N];
    logic [31:0] n_hash [sha256s_pkg::HASH_N];
    logic [31:0] r_v    [sha256s_pkg::HASH_N];
    logic [31:0] n_v    [sha256s_pkg::HASH_N];
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    // a..h live in r_v[0..7]
    always_comb begin
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1  = r_v[7] + sha256s_pkg::bsig1(r_v[4]) + w_ch + i_k + i_w;
        w_t2  = sha256s_pkg::bsig0(r_v[0]) + w_maj;
    end

    always_comb begin
        n_v    = r_v;
        n_hash = r_hash;
        if (i_ctl.load) begin
            n_v = r_hash;
        end else if (i_ctl.step) begin
            n_v[7] = r_v[6];
            n_v[6] = r_v[5];
            n_v[5] = r_v[4];
            n_v[4] = r_v[3] + w_t1;
            n_v[3] = r_v[2];
            n_v[2] = r_v[1];
            n_v[1] = r_v[0];
            n_v[0] = w_t1 + w_t2;
        end
        if (i_ctl.init) begin
            n_hash = sha256s_pkg::IV;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < sha256s_pkg::HASH_N; i++) begin
                n_hash[i] = r_hash[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= sha256s_pkg::IV;
        end else begin
            r_hash <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_hash = r_hash[i_sel];

endmodule

// File: hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial sha-256 with padding, length field and word-wise digest output
// ----------------------------------------------------------------------------
// The block takes one message byte per accepted word and collects 64 of them
// into a block buffer that doubles as the message schedule window. While it
// fills, a byte is taken every cycle. When the 64th byte lands, o_stall rises
// and stays high while one shared round unit does the 64 compression rounds,
// one round per cycle, and then adds the working variables into the hash
// words. The single round unit thus paces a steady stream. A word with
// i_message_end high closes the message (after its byte, if i_byte_present is
// high); the sequencer then feeds the 0x80 mark, zeros and the 64-bit
// big-endian bit length into the buffer at one byte per cycle, compresses
// once or twice, and presents the digest as eight 32-bit words, word 0 first,
// with o_last_word on the eighth. Input stays stalled until the last digest
// word is taken, after which the hash restarts from the initial values.
// A word with neither a byte nor an end mark is taken and changes nothing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256s_pkg::t_state   r_state;
    sha256s_pkg::t_state   n_state;
    sha256s_pkg::t_sch_ctl w_sch_ctl;
    sha256s_pkg::t_rnd_ctl w_rnd_ctl;

    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [60:0] r_byte_count;
    logic [60:0] n_byte_count;
    logic [5:0]  r_round;
    logic [5:0]  n_round;
    logic [2:0]  r_out_idx;
    logic [2:0]  n_out_idx;
    logic        r_padding;     // message closed, padding still owed
    logic        n_padding;
    logic        r_mark_done;   // 0x80 mark already in the buffer
    logic        n_mark_done;
    logic        r_len_phase;   // length field being written
    logic        n_len_phase;

    logic        w_take;
    logic        w_push;
    logic        w_out_take;
    logic [7:0]  w_byte;
    logic [7:0]  w_pad_byte;
    logic [63:0] w_len_sh;
    logic [31:0] w_sched_word;

    // length byte i of the big-endian bit count sits at fill 56 + i
    assign w_len_sh = {r_byte_count, 3'b000} << {r_fill[2:0], 3'b000};

    always_comb begin
        if (!r_mark_done) begin
            w_pad_byte = sha256s_pkg::PAD_MARK;
        end else if (r_len_phase || r_fill == sha256s_pkg::LEN_POS) begin
            w_pad_byte = w_len_sh[63:56];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sha256s_pkg::ST_COLLECT: begin
                if (i_valid) begin
                    if (i_byte_present && r_fill == sha256s_pkg::FILL_LAST) begin
                        n_state = sha256s_pkg::ST_ROUND;
                    end else if (i_message_end) begin
                        n_state = sha256s_pkg::ST_PAD;
                    end
                end
            end
            sha256s_pkg::ST_ROUND: begin
                if (r_round == sha256s_pkg::ROUND_LAST) begin
                    n_state = sha256s_pkg::ST_FOLD;
                end
            end
            sha256s_pkg::ST_FOLD: begin
                if (!r_padding) begin
                    n_state = sha256s_pkg::ST_COLLECT;
                end else if (r_len_phase) begin
                    n_state = sha256s_pkg::ST_OUT;
                end else begin
                    n_state = sha256s_pkg::ST_PAD;
                end
            end
            sha256s_pkg::ST_PAD: begin
                if (r_fill == sha256s_pkg::FILL_LAST) begin
                    n_state = sha256s_pkg::ST_ROUND;
                end
            end
            sha256s_pkg::ST_OUT: begin
                if (!i_stall && r_out_idx == sha256s_pkg::WORD_LAST) begin
                    n_state = sha256s_pkg::ST_COLLECT;
                end
            end
            default: begin
                n_state = sha256s_pkg::ST_COLLECT;
            end
        endcase
    end

    // outputs and unit controls
    always_comb begin
        o_stall         = (r_state != sha256s_pkg::ST_COLLECT);
        o_valid         = (r_state == sha256s_pkg::ST_OUT);
        w_take          = (r_state == sha256s_pkg::ST_COLLECT) && i_valid;
        w_out_take      = o_valid && !i_stall;
        w_push          = (w_take && i_byte_present) || (r_state == sha256s_pkg::ST_PAD);
        w_byte          = (r_state == sha256s_pkg::ST_PAD) ? w_pad_byte : i_data_byte;
        w_sch_ctl.push  = w_push;
        w_sch_ctl.shift = (r_state == sha256s_pkg::ST_ROUND);
        w_rnd_ctl.load  = w_push && r_fill == sha256s_pkg::FILL_LAST;
        w_rnd_ctl.step  = (r_state == sha256s_pkg::ST_ROUND);
        w_rnd_ctl.fold  = (r_state == sha256s_pkg::ST_FOLD);
        w_rnd_ctl.init  = w_out_take && r_out_idx == sha256s_pkg::WORD_LAST;
    end

    // counters and padding flags
    always_comb begin
        n_fill       = w_push ? r_fill + 6'd1 : r_fill;
        n_byte_count = r_byte_count;
        n_padding    = r_padding;
        n_mark_done  = r_mark_done;
        n_len_phase  = r_len_phase;
        n_round      = (r_state == sha256s_pkg::ST_ROUND) ? r_round + 6'd1 : 6'd0;
        n_out_idx    = w_out_take ? r_out_idx + 3'd1 : r_out_idx;
        if (w_take && i_byte_present) begin
            n_byte_count = r_byte_count + 61'd1;
        end
        if (w_take && i_message_end) begin
            n_padding = 1'b1;
        end
        if (r_state == sha256s_pkg::ST_PAD) begin
            n_mark_done = 1'b1;
            if (r_mark_done && r_fill == sha256s_pkg::LEN_POS) begin
                n_len_phase = 1'b1;
            end
        end
        if (w_rnd_ctl.init) begin
            n_byte_count = '0;
            n_padding    = 1'b0;
            n_mark_done  = 1'b0;
            n_len_phase  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sha256s_pkg::ST_COLLECT;
            r_fill       <= '0;
            r_byte_count <= '0;
            r_round      <= '0;
            r_out_idx    <= '0;
            r_padding    <= 1'b0;
            r_mark_done  <= 1'b0;
            r_len_phase  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_byte_count <= n_byte_count;
            r_round      <= n_round;
            r_out_idx    <= n_out_idx;
            r_padding    <= n_padding;
            r_mark_done  <= n_mark_done;
            r_len_phase  <= n_len_phase;
        end
    end

    sha256s_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_sch_ctl),
        .i_byte (w_byte),
        .o_word (w_sched_word)
    );

    sha256s_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rnd_ctl),
        .i_k     (sha256s_pkg::K_TABLE[r_round]),
        .i_w     (w_sched_word),
        .i_sel   (r_out_idx),
        .o_hash  (o_digest_word)
    );

    assign o_word_index = r_out_idx;
    assign o_last_word  = (r_out_idx == sha256s_pkg::WORD_LAST);

    // digest only shows with an empty block buffer
    a_out_empty_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_fill == 6'd0)
        else $error("digest presented with a partly filled block");

    // the last round is always followed by the fold
    a_round_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256s_pkg::ST_ROUND && r_round == sha256s_pkg::ROUND_LAST)
        |=> r_state == sha256s_pkg::ST_FOLD)
        else $error("compression did not end in the fold");

    // fold after the length block starts digest output
    a_len_fold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256s_pkg::ST_FOLD && r_len_phase) |=> o_valid)
        else $error("digest not presented after the final block");

    // last digest word taken restarts the message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word)
        |=> (r_byte_count == 61'd0 && r_state == sha256s_pkg::ST_COLLECT && !r_padding))
        else $error("message state not cleared after the digest");

endmodule
